### sv/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg
// Shared types and constants for the linear interpolation resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package lir_pkg;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int DIFF_W   = 17;
  localparam int STEP_W   = 21;
  localparam int PHASE_W  = 22;
  localparam int PROD_W   = 34;

  // phase constants, unsigned q6.16 (step q5.16)
  localparam logic [PHASE_W-1:0] PHASE_ONE  = 22'h010000;
  localparam logic [STEP_W-1:0]  STEP_MIN   = 21'd1024;
  localparam logic [STEP_W-1:0]  STEP_RESET = 21'd65536;

  // default queue depths
  localparam int CMD_DEPTH_DEF = 4;
  localparam int RES_DEPTH_DEF = 4;

  // command word from front to back
  typedef struct packed {
    logic                       run;   // 0: store only, 1: interpolate a run
    logic signed [SAMPLE_W-1:0] prev;
    logic signed [DIFF_W-1:0]   diff;
  } cmd_t;

  // result word from back to output queue
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } res_t;

endpackage

`default_nettype wire

### sv/lir_fifo.sv
// ----------------------------------------------------------------------------
// lir_fifo
// Small register queue with first-word fall-through read and a fill level.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_en,
  input  wire logic [WIDTH-1:0]                 wr_data,
  input  wire logic                             rd_en,
  output logic      [WIDTH-1:0]                 rd_data,
  output logic                                  full,
  output logic                                  empty,
  output logic      [$clog2(DEPTH+1)-1:0]       level
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // status
  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign level   = count;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (rd_en) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/lir_front.sv
// ----------------------------------------------------------------------------
// lir_front
// Accepts input samples, decides store versus run and forms the difference
// to the previous sample for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 push,
  input  wire logic signed [lir_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic                                 restart,
  output logic                                      full,
  input  wire logic                                 cmd_full,
  output logic                                      cmd_push,
  output lir_pkg::cmd_t                             cmd_data
);

  logic signed [lir_pkg::SAMPLE_W-1:0] prev_sample;
  logic                                have_previous;
  logic                                take;

  assign full = cmd_full;
  assign take = push && !cmd_full;

  // classify and form the command word
  always_comb begin
    cmd_push      = take;
    cmd_data.run  = !restart && have_previous;
    cmd_data.prev = prev_sample;
    cmd_data.diff = {sample[lir_pkg::SAMPLE_W-1], sample}
                  - {prev_sample[lir_pkg::SAMPLE_W-1], prev_sample};
  end

  // previous sample tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample   <= '0;
      have_previous <= 1'b0;
    end else if (take) begin
      prev_sample   <= sample;
      have_previous <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### sv/lir_back.sv
// ----------------------------------------------------------------------------
// lir_back
// Walks the phase through one run per command, one output per cycle while the
// result queue has room; a registered multiply stage precedes the final add.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_back #(
  parameter int RES_DEPTH = lir_pkg::RES_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic [lir_pkg::STEP_W-1:0]            phase_step,
  input  wire logic                                  cmd_valid,
  input  wire lir_pkg::cmd_t                         cmd_head,
  output logic                                       cmd_pop,
  input  wire logic [$clog2(RES_DEPTH+1)-1:0]        res_level,
  output logic                                       res_push,
  output lir_pkg::res_t                              res_data
);

  localparam int LW = $clog2(RES_DEPTH + 1);

  logic [lir_pkg::PHASE_W-1:0]       phase;
  logic [lir_pkg::PHASE_W-1:0]       phase_next;
  logic [lir_pkg::PHASE_W-1:0]       phase_adv;
  logic [lir_pkg::PHASE_W-1:0]       phase_wrap;
  logic [lir_pkg::STEP_W-1:0]        step_eff;
  logic [LW:0]                       occupied;
  logic                              space;
  logic                              in_range;
  logic                              issue;
  logic signed [lir_pkg::PROD_W-1:0] product;

  // pipeline register between multiply and add
  logic                                pipe_v;
  logic                                pipe_last;
  logic signed [lir_pkg::SAMPLE_W-1:0] pipe_prev;
  logic signed [lir_pkg::PROD_W-1:0]   pipe_prod;

  // clamp the step so a run never exceeds 64 outputs
  assign step_eff   = (phase_step < lir_pkg::STEP_MIN) ? lir_pkg::STEP_MIN : phase_step;
  assign phase_adv  = phase + {1'b0, step_eff};
  assign phase_wrap = phase - lir_pkg::PHASE_ONE;
  assign in_range   = (phase < lir_pkg::PHASE_ONE);

  // room in the result queue, counting the word in flight
  assign occupied = {1'b0, res_level} + (LW+1)'(pipe_v);
  assign space    = occupied < (LW+1)'(RES_DEPTH);

  assign product = $signed({1'b0, phase[lir_pkg::SAMPLE_W-1:0]}) * cmd_head.diff;

  // run control
  always_comb begin
    phase_next = phase;
    cmd_pop    = 1'b0;
    issue      = 1'b0;
    if (cmd_valid) begin
      if (!cmd_head.run) begin
        phase_next = '0;
        cmd_pop    = 1'b1;
      end else if (in_range) begin
        if (space) begin
          issue      = 1'b1;
          phase_next = phase_adv;
        end
      end else begin
        phase_next = {1'b0, phase_wrap[lir_pkg::STEP_W-1:0]};
        cmd_pop    = 1'b1;
      end
    end
  end

  // phase and pipeline valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= '0;
      pipe_v <= 1'b0;
    end else begin
      phase  <= phase_next;
      pipe_v <= issue;
    end
  end

  // multiply stage payload
  always_ff @(posedge clk) begin
    if (issue) begin
      pipe_prod <= product;
      pipe_prev <= cmd_head.prev;
      pipe_last <= !(phase_adv < lir_pkg::PHASE_ONE);
    end
  end

  // add stage: prev plus product shifted down by 16, result stays in range
  always_comb begin
    res_push       = pipe_v;
    res_data.value = pipe_prev + pipe_prod[31:16];
    res_data.last  = pipe_last;
  end

endmodule

`default_nettype wire

### sv/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Linear interpolation sample rate converter with a q5.16 phase step.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  input     in         push / full        sample, restart
//  result    out        pop / empty        out_sample, last_of_run
//  config    in         cfg_valid / ready  cfg_data (phase_step)
//
//  An input sample that starts a run gives its n outputs, one per cycle while
//  the result queue has room, then the phase is retired; a store only sample
//  is popped with no output. The single phase loop ends one command before the
//  next. The product is registered, and the add writes the result queue.
//  Reset is synchronous; it empties both queues and clears the phase and the
//  stored sample. Input stalls only when the command queue is full, the back
//  end stalls only when the result queue has no room.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_interp_resampler #(
  parameter int CMD_DEPTH = lir_pkg::CMD_DEPTH_DEF,
  parameter int RES_DEPTH = lir_pkg::RES_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic signed [lir_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic                                 restart,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic signed [lir_pkg::SAMPLE_W-1:0]       out_sample,
  output logic                                      last_of_run,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [lir_pkg::STEP_W-1:0]           cfg_data
);

  logic [lir_pkg::STEP_W-1:0] phase_step;

  lir_pkg::cmd_t cmd_in;
  lir_pkg::cmd_t cmd_head;
  logic          cmd_push;
  logic          cmd_pop;
  logic          cmd_full;
  logic          cmd_empty;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_level;

  lir_pkg::res_t res_in;
  lir_pkg::res_t res_head;
  logic          res_push;
  logic          res_full;
  logic [$clog2(RES_DEPTH+1)-1:0] res_level;

  // config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= lir_pkg::STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      phase_step <= cfg_data;
    end
  end

  // front end
  lir_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .sample   (sample),
    .restart  (restart),
    .full     (full),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in)
  );

  // command queue
  lir_fifo #(
    .WIDTH ($bits(lir_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head),
    .full    (cmd_full),
    .empty   (cmd_empty),
    .level   (cmd_level)
  );

  // back end
  lir_back #(
    .RES_DEPTH (RES_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .phase_step (phase_step),
    .cmd_valid  (!cmd_empty && (cmd_level != '0)),
    .cmd_head   (cmd_head),
    .cmd_pop    (cmd_pop),
    .res_level  (res_level),
    .res_push   (res_push),
    .res_data   (res_in)
  );

  // result queue
  lir_fifo #(
    .WIDTH ($bits(lir_pkg::res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push && !res_full),
    .wr_data (res_in),
    .rd_en   (pop && !empty),
    .rd_data (res_head),
    .full    (res_full),
    .empty   (empty),
    .level   (res_level)
  );

  assign out_sample  = res_head.value;
  assign last_of_run = res_head.last;

endmodule

`default_nettype wire

### sv/lir_checker.sv
// ----------------------------------------------------------------------------
// lir_checker
// Port level checks on the resampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lir_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 push,
  input wire logic                                 full,
  input wire logic                                 empty,
  input wire logic                                 pop,
  input wire logic signed [lir_pkg::SAMPLE_W-1:0]  out_sample,
  input wire logic                                 last_of_run,
  input wire logic                                 cfg_ready
);

  // reset leaves no result word
  a_reset_empty : assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // reset leaves room for input
  a_reset_room : assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  // a waiting result word holds until popped
  a_hold : assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_sample) && $stable(last_of_run)))
    else $error("result word changed while waiting");

  // input side only fills up through an accepted word
  a_full_rise : assert property (@(posedge clk) disable iff (rst)
    (!full && !push) |=> !full)
    else $error("input full without an accepted word");

  // config register always takes a write
  a_cfg_ready : assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config channel not ready");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (.*);

`default_nettype wire
